// ===== src/rca_pkg.sv =====
package rca_pkg;

  localparam int CACHE_BYTES_W = 21;
  localparam int RES_COUNT_W   = 13;
  localparam int RESOURCE_W    = 12;
  localparam int LENGTH_W      = 24;
  localparam int FPOS_W        = 32;
  localparam int STATUS_W      = 3;
  localparam int OFFSET_W      = 20;
  localparam int EVICT_W       = 13;
  localparam int SIZE_W        = LENGTH_W + 1;
  localparam int S_TDATA_W     = 72;
  localparam int M_TDATA_W     = 96;
  localparam int APB_ADDR_W    = 3;
  localparam int APB_DATA_W    = 32;

  localparam int DEF_RESOURCE_SLOTS  = 4096;
  localparam int DEF_CACHE_ADDR_BITS = 20;

  localparam logic [CACHE_BYTES_W-1:0] CACHE_BYTES_RST = 21'd65536;
  localparam logic [RES_COUNT_W-1:0]   RES_COUNT_RST   = 13'd4096;

  localparam logic [SIZE_W-1:0] MIN_SIZE   = 25'd4;
  localparam logic [SIZE_W-1:0] ALIGN_ADD  = 25'd3;
  localparam logic [SIZE_W-1:0] ALIGN_MASK = ~25'd3;

  typedef enum logic [STATUS_W-1:0] {
    STAT_HIT    = 3'd0,
    STAT_PLACED = 3'd1,
    STAT_BAD    = 3'd2,
    STAT_LARGE  = 3'd3,
    STAT_FLUSH  = 3'd4
  } status_e;

  typedef enum logic {
    OP_BORROW = 1'b0,
    OP_FLUSH  = 1'b1
  } op_e;

  typedef enum logic {
    REG_CACHE_BYTES    = 1'b0,
    REG_RESOURCE_COUNT = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_FIT,
    ST_WALK,
    ST_PLACE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [CACHE_BYTES_W-1:0] cache_bytes;
    logic [RES_COUNT_W-1:0]   resource_count;
  } cfg_t;

  function automatic logic [SIZE_W-1:0] round_size(input logic [LENGTH_W-1:0] len);
    logic [SIZE_W-1:0] s;
    s = ({1'b0, len} + ALIGN_ADD) & ALIGN_MASK;
    return (len == '0) ? MIN_SIZE : s;
  endfunction

endpackage

// ===== src/rca_ram.sv =====
module rca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/rca_cfg.sv =====
module rca_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rca_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [rca_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [rca_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output rca_pkg::cfg_t                    cfg_o
);

  rca_pkg::cfg_t cfg_q, cfg_d;
  rca_pkg::reg_e sel;
  logic          wr;

  assign sel    = rca_pkg::reg_e'(paddr[2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (sel)
        rca_pkg::REG_CACHE_BYTES:    cfg_d.cache_bytes    = pwdata[rca_pkg::CACHE_BYTES_W-1:0];
        rca_pkg::REG_RESOURCE_COUNT: cfg_d.resource_count = pwdata[rca_pkg::RES_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      rca_pkg::REG_CACHE_BYTES:    prdata = rca_pkg::APB_DATA_W'(cfg_q.cache_bytes);
      rca_pkg::REG_RESOURCE_COUNT: prdata = rca_pkg::APB_DATA_W'(cfg_q.resource_count);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cache_bytes    <= rca_pkg::CACHE_BYTES_RST;
      cfg_q.resource_count <= rca_pkg::RES_COUNT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/circular_render_cache_allocator.sv =====
// Placement runs an eviction walk that reads one directory RAM slot per cycle through
// one overlap comparator. Flush reruns the clearing pass over every directory slot.
// Hit, too large and bad resource number skip the walk. One item in flight at a time.
// The result sits in an output register; the next beat is taken while it waits.
// After reset a clearing pass zeroes every directory slot while the input is not ready.
module circular_render_cache_allocator #(
  parameter int RESOURCE_SLOTS  = rca_pkg::DEF_RESOURCE_SLOTS,
  parameter int CACHE_ADDR_BITS = rca_pkg::DEF_CACHE_ADDR_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rca_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [rca_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [rca_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // resource[11:0], length[35:12], file_pos[67:36], zero pad
  input  logic [rca_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  // op[0]
  input  logic [0:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // cache_offset[19:0], fetch_pos[51:20], fetch_bytes[75:52], evicted_count[88:76], zero pad
  output logic [rca_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  // status[2:0]
  output logic [rca_pkg::STATUS_W-1:0]       m_axis_tuser
);

  localparam int IW    = $clog2(RESOURCE_SLOTS);
  localparam int CAB   = CACHE_ADDR_BITS;
  localparam int CW    = CAB + 1;
  localparam int LW    = rca_pkg::LENGTH_W;
  localparam int WW    = 1 + CAB + LW;
  localparam int EVW   = $clog2(RESOURCE_SLOTS + 1);
  localparam int CMPW  = (CW > rca_pkg::CACHE_BYTES_W) ? CW : rca_pkg::CACHE_BYTES_W;
  localparam int MW    = ((CAB > LW) ? CAB : LW) + 2;
  localparam logic [CMPW-1:0] CAP_LIM = CMPW'(1) << CAB;
  localparam logic [IW-1:0]   LAST    = IW'(RESOURCE_SLOTS - 1);
  localparam logic [rca_pkg::RES_COUNT_W-1:0] SLOTS_CNT = rca_pkg::RES_COUNT_W'(RESOURCE_SLOTS);

  rca_pkg::cfg_t    cfg;
  rca_pkg::state_e  state_q, state_d;
  rca_pkg::status_e status_q, status_d;

  logic [IW-1:0]                     idx_q, idx_d;
  logic [CW-1:0]                     cursor_q, cursor_d;
  logic [CW-1:0]                     start_q, start_d;
  logic [CW-1:0]                     end_q, end_d;
  logic [EVW-1:0]                    evict_q, evict_d;
  logic [rca_pkg::RESOURCE_W-1:0]    res_q, res_d;
  logic [LW-1:0]                     len_q, len_d;
  logic [rca_pkg::FPOS_W-1:0]        fpos_q, fpos_d;
  logic [rca_pkg::SIZE_W-1:0]        size_q, size_d;

  logic                              out_valid_q, out_valid_d;
  logic [rca_pkg::M_TDATA_W-1:0]     out_data_q, out_data_d;
  logic [rca_pkg::STATUS_W-1:0]      out_user_q, out_user_d;

  logic                              ram_we;
  logic [IW-1:0]                     ram_waddr, ram_raddr;
  logic [WW-1:0]                     ram_wdata, ram_rdata;

  logic                              accept, bad, out_free, ovl;
  logic [rca_pkg::RESOURCE_W-1:0]    in_res;
  logic [LW-1:0]                     in_len;
  logic [rca_pkg::FPOS_W-1:0]        in_fpos;
  logic [rca_pkg::RES_COUNT_W-1:0]   eff_count;
  logic [CMPW-1:0]                   cap_full;
  logic [CW-1:0]                     cap;
  logic                              rd_resident;
  logic [CAB-1:0]                    rd_offset;
  logic [LW-1:0]                     rd_length;
  logic [MW-1:0]                     rd_span;
  logic [rca_pkg::OFFSET_W-1:0]      r_offset;
  logic [rca_pkg::FPOS_W-1:0]        r_fpos;
  logic [LW-1:0]                     r_bytes;
  logic [rca_pkg::EVICT_W-1:0]       r_evict;

  rca_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rca_ram #(
    .WIDTH (WW),
    .DEPTH (RESOURCE_SLOTS)
  ) u_dir (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_res  = s_axis_tdata[11:0];
  assign in_len  = s_axis_tdata[35:12];
  assign in_fpos = s_axis_tdata[67:36];

  assign s_axis_tready = (state_q == rca_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~out_valid_q | m_axis_tready;

  assign eff_count = (cfg.resource_count > SLOTS_CNT) ? SLOTS_CNT : cfg.resource_count;
  assign bad       = ({1'b0, in_res} >= eff_count);

  assign cap_full = (CMPW'(cfg.cache_bytes) > CAP_LIM) ? CAP_LIM : CMPW'(cfg.cache_bytes);
  assign cap      = cap_full[CW-1:0];

  assign rd_resident = ram_rdata[WW-1];
  assign rd_offset   = ram_rdata[CAB+LW-1:LW];
  assign rd_length   = ram_rdata[LW-1:0];
  assign rd_span     = MW'(rd_offset) + ((rd_length == '0) ? MW'(4) : MW'(rd_length));
  assign ovl         = rd_resident & (MW'(rd_offset) < MW'(end_q)) & (MW'(start_q) < rd_span);

  // next state and datapath
  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    idx_d    = idx_q;
    cursor_d = cursor_q;
    start_d  = start_q;
    end_d    = end_q;
    evict_d  = evict_q;
    res_d    = res_q;
    len_d    = len_q;
    fpos_d   = fpos_q;
    size_d   = size_q;
    unique case (state_q)
      rca_pkg::ST_CLEAR: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == LAST) begin
          state_d = (status_q == rca_pkg::STAT_FLUSH) ? rca_pkg::ST_DONE : rca_pkg::ST_IDLE;
        end
      end
      rca_pkg::ST_IDLE: begin
        if (accept) begin
          res_d   = in_res;
          len_d   = in_len;
          fpos_d  = in_fpos;
          size_d  = rca_pkg::round_size(in_len);
          evict_d = '0;
          if (s_axis_tuser == rca_pkg::OP_FLUSH) begin
            status_d = rca_pkg::STAT_FLUSH;
            cursor_d = '0;
            idx_d    = '0;
            state_d  = rca_pkg::ST_CLEAR;
          end else if (bad) begin
            status_d = rca_pkg::STAT_BAD;
            state_d  = rca_pkg::ST_DONE;
          end else begin
            state_d = rca_pkg::ST_LOOKUP;
          end
        end
      end
      rca_pkg::ST_LOOKUP: begin
        if (rd_resident) begin
          status_d = rca_pkg::STAT_HIT;
          start_d  = CW'(rd_offset);
          state_d  = rca_pkg::ST_DONE;
        end else if (MW'(size_q) > MW'(cap)) begin
          status_d = rca_pkg::STAT_LARGE;
          state_d  = rca_pkg::ST_DONE;
        end else begin
          start_d = (MW'(cursor_q) + MW'(size_q) > MW'(cap)) ? '0 : cursor_q;
          state_d = rca_pkg::ST_FIT;
        end
      end
      rca_pkg::ST_FIT: begin
        end_d   = CW'(MW'(start_q) + MW'(size_q));
        idx_d   = '0;
        state_d = rca_pkg::ST_WALK;
      end
      rca_pkg::ST_WALK: begin
        if (ovl) begin
          evict_d = evict_q + 1'b1;
        end
        idx_d = idx_q + 1'b1;
        if (idx_q == LAST) begin
          state_d = rca_pkg::ST_PLACE;
        end
      end
      rca_pkg::ST_PLACE: begin
        cursor_d = end_q;
        status_d = rca_pkg::STAT_PLACED;
        state_d  = rca_pkg::ST_DONE;
      end
      rca_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = rca_pkg::ST_IDLE;
        end
      end
      default: state_d = rca_pkg::ST_IDLE;
    endcase
  end

  // directory RAM controls
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = '0;
    ram_raddr = in_res[IW-1:0];
    unique case (state_q)
      rca_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
      end
      rca_pkg::ST_FIT: begin
        ram_raddr = '0;
      end
      rca_pkg::ST_WALK: begin
        ram_we    = ovl;
        ram_wdata = {1'b0, ram_rdata[WW-2:0]};
        ram_raddr = idx_q + 1'b1;
      end
      rca_pkg::ST_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = res_q[IW-1:0];
        ram_wdata = {1'b1, start_q[CAB-1:0], len_q};
      end
      default: ;
    endcase
  end

  // result fields; unused fields read as zero
  always_comb begin
    r_offset = '0;
    r_fpos   = '0;
    r_bytes  = '0;
    r_evict  = '0;
    if (status_q == rca_pkg::STAT_HIT || status_q == rca_pkg::STAT_PLACED) begin
      r_offset = rca_pkg::OFFSET_W'(start_q);
    end
    if (status_q == rca_pkg::STAT_PLACED) begin
      r_fpos  = fpos_q;
      r_bytes = len_q;
      r_evict = rca_pkg::EVICT_W'(evict_q);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q & ~m_axis_tready;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    if (state_q == rca_pkg::ST_DONE && out_free) begin
      out_valid_d = 1'b1;
      out_data_d  = rca_pkg::M_TDATA_W'({r_evict, r_bytes, r_fpos, r_offset});
      out_user_d  = status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rca_pkg::ST_CLEAR;
      status_q    <= rca_pkg::STAT_HIT;
      idx_q       <= '0;
      cursor_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      status_q    <= status_d;
      idx_q       <= idx_d;
      cursor_q    <= cursor_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q    <= start_d;
    end_q      <= end_d;
    evict_q    <= evict_d;
    res_q      <= res_d;
    len_q      <= len_d;
    fpos_q     <= fpos_d;
    size_q     <= size_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule
